// File: sv/event_rate_zscore_detector_core_assert.svh
// Assertion macros for the event rate z-score detector.
`ifndef EVENT_RATE_ZSCORE_DETECTOR_CORE_ASSERT_SVH
`define EVENT_RATE_ZSCORE_DETECTOR_CORE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define ERZD_ASSERT_ALWAYS(lbl, expr, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ERZD_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/erzd_pkg.sv
// ----------------------------------------------------------------------------
// erzd_pkg
// Shared constants, types and state codes of the event rate z-score detector.
// ----------------------------------------------------------------------------
`default_nettype none

package erzd_pkg;

   localparam int WINDOW_DEPTH = 60;
   localparam int COUNT_WIDTH  = 24;
   localparam int PTR_W        = $clog2(WINDOW_DEPTH);
   localparam int N_W          = $clog2(WINDOW_DEPTH + 1);
   localparam int S_W          = COUNT_WIDTH + N_W;
   localparam int Q_W          = 2 * COUNT_WIDTH + N_W;
   localparam int D_W          = Q_W + N_W;
   localparam int FRAC_W       = 10;
   localparam int X_W          = 2 * S_W + 2 * FRAC_W;
   localparam int Z_W          = 16;
   localparam int SWP_W        = $clog2(WINDOW_DEPTH + 3);
   localparam int DIVC_W       = $clog2(X_W);
   localparam int BIT_W        = $clog2(Z_W);
   localparam int RATE_W       = 24;
   localparam int STAMP_W      = 32;
   localparam int SCORE_W      = 16;
   localparam int SUM_W        = 19;

   localparam int MIN_W        = 6;
   localparam int MULT_W       = 4;
   localparam int DIV_W        = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_MULT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEC_DIV   = 2'd2;

   localparam logic [MIN_W-1:0]  MIN_VALID_RST  = 6'd5;
   localparam logic [MULT_W-1:0] SPIKE_MULT_RST = 4'd3;
   localparam logic [DIV_W-1:0]  EXEC_DIV_RST   = 8'd10;

   localparam logic [1:0] KIND_EXEC = 2'd0;

   localparam logic signed [SUM_W-1:0] EXEC_BOOST  = 19'sd1024;
   localparam logic signed [SUM_W-1:0] SPIKE_BOOST = 19'sd1536;
   localparam logic signed [SUM_W-1:0] SCORE_MAX   = 19'sd32767;
   localparam logic signed [SUM_W-1:0] SCORE_MIN   = -19'sd32768;

   typedef struct packed {
      logic [STAMP_W-1:0]     stamp;
      logic [COUNT_WIDTH-1:0] rate;
      logic [COUNT_WIDTH-1:0] execs;
   } tick_type;

   typedef struct packed {
      logic [MIN_W-1:0]  min_valid;
      logic [MULT_W-1:0] spike_mult;
      logic [DIV_W-1:0]  exec_div;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SWEEP,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_SQRT,
      ST_SCORE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// File: sv/erzd_front.sv
// ----------------------------------------------------------------------------
// erzd_front
// Counts event beats per second and hands each tick to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module erzd_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [39:0]             req_tdata,
   input  wire logic [0:0]              req_tuser,
   input  wire logic                    q_full,
   output logic                         q_push,
   output erzd_pkg::tick_type           q_data
);

   localparam logic [erzd_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [erzd_pkg::COUNT_WIDTH-1:0] total_ff, total_in;
   logic [erzd_pkg::COUNT_WIDTH-1:0] exec_ff, exec_in;
   logic                             accept;
   logic [1:0]                       kind;

   assign kind       = req_tdata[1:0];
   assign req_tready = !req_tuser[0] || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && req_tuser[0];

   always_comb begin
      q_data.stamp = req_tdata[33:2];
      q_data.rate  = total_ff;
      q_data.execs = exec_ff;
   end

   always_comb begin
      total_in = total_ff;
      exec_in  = exec_ff;
      if (accept) begin
         if (req_tuser[0]) begin
            total_in = '0;
            exec_in  = '0;
         end else begin
            if (total_ff != CNT_MAX) total_in = total_ff + 1'b1;
            if (kind == erzd_pkg::KIND_EXEC && exec_ff != CNT_MAX) exec_in = exec_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         exec_ff  <= '0;
      end else begin
         total_ff <= total_in;
         exec_ff  <= exec_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/erzd_queue.sv
// ----------------------------------------------------------------------------
// erzd_queue
// Two-entry queue of closed seconds between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module erzd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire erzd_pkg::tick_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output erzd_pkg::tick_type      pop_data
);

   erzd_pkg::tick_type slot_ff [2];
   logic               wr_ff, rd_ff;
   logic [1:0]         count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

// File: sv/erzd_back.sv
// ----------------------------------------------------------------------------
// erzd_back
// Window store, statistics sweep, serial divide and root, score output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_rate_zscore_detector_core_assert.svh"

module erzd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire erzd_pkg::cfg_type       cfg,
   input  wire logic                    q_valid,
   input  wire erzd_pkg::tick_type      q_data,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [71:0]                  rsp_tdata
);

   localparam int DEPTH = erzd_pkg::WINDOW_DEPTH;
   localparam int CW    = erzd_pkg::COUNT_WIDTH;
   localparam int D_W   = erzd_pkg::D_W;
   localparam int X_W   = erzd_pkg::X_W;
   localparam int S_W   = erzd_pkg::S_W;
   localparam int Z_W   = erzd_pkg::Z_W;
   localparam int SPK_W = S_W + erzd_pkg::MULT_W;

   erzd_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 mem [DEPTH];
   logic [DEPTH-1:0]              valid_ff;
   logic [erzd_pkg::PTR_W-1:0]    ptr_ff;
   logic [CW-1:0]                 rd_data_ff;
   logic                          rd_ok_ff, rd_vld_ff;
   logic [2*CW-1:0]               sq_ff;
   logic [CW-1:0]                 v2_ff;
   logic                          sq_vld_ff;
   logic [erzd_pkg::SWP_W-1:0]    swp_ff;
   logic [erzd_pkg::N_W-1:0]      n_ff;
   logic [S_W-1:0]                s_ff;
   logic [erzd_pkg::Q_W-1:0]      qs_ff;
   erzd_pkg::tick_type            tick_ff;
   logic [D_W-1:0]                nq_ff, ss_ff, d_ff;
   logic [S_W-1:0]                nr_ff;
   logic                          exb_ff, spb_ff, zen_ff, neg_ff;
   logic [D_W-1:0]                rem_ff;
   logic [X_W-1:0]                quo_ff;
   logic [erzd_pkg::DIVC_W-1:0]   cnt_ff;
   logic [Z_W-1:0]                root_ff;
   logic [erzd_pkg::BIT_W-1:0]    bit_ff;
   logic [erzd_pkg::SCORE_W-1:0]  score_ff;

   logic                          issue;
   logic [erzd_pkg::PTR_W-1:0]    rd_addr;
   logic [CW-1:0]                 rd_val;
   logic [S_W-1:0]                mag;
   logic [D_W:0]                  rem_sh;
   logic                          ge;
   logic [Z_W-1:0]                trial;
   logic [2*Z_W-1:0]              trial_sq;
   logic                          root_ok;
   logic signed [erzd_pkg::SUM_W-1:0] zval, sum;

   assign q_pop      = state_ff == erzd_pkg::ST_IDLE && q_valid;
   assign rsp_tvalid = state_ff == erzd_pkg::ST_OUT;
   assign rsp_tdata  = {score_ff, erzd_pkg::RATE_W'(tick_ff.rate), tick_ff.stamp};

   assign issue   = state_ff == erzd_pkg::ST_SWEEP && swp_ff < erzd_pkg::SWP_W'(DEPTH);
   assign rd_addr = swp_ff[erzd_pkg::PTR_W-1:0];
   assign rd_val  = rd_ok_ff ? rd_data_ff : '0;
   assign mag     = (nr_ff >= s_ff) ? nr_ff - s_ff : s_ff - nr_ff;
   assign rem_sh  = {rem_ff, quo_ff[X_W-1]};
   assign ge      = rem_sh >= {1'b0, d_ff};
   assign trial   = root_ff | (Z_W'(1) << bit_ff);
   assign trial_sq = (2*Z_W)'(trial) * (2*Z_W)'(trial);
   assign root_ok = (|quo_ff[X_W-1:2*Z_W]) || ({1'b0, trial_sq} <= {1'b0, quo_ff[2*Z_W-1:0]});

   always_comb begin
      zval = '0;
      if (zen_ff) zval = neg_ff ? -$signed({3'b0, root_ff}) : $signed({3'b0, root_ff});
      sum = zval + (exb_ff ? erzd_pkg::EXEC_BOOST : '0) + (spb_ff ? erzd_pkg::SPIKE_BOOST : '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erzd_pkg::ST_IDLE:  if (q_valid) state_in = erzd_pkg::ST_WRITE;
         erzd_pkg::ST_WRITE: state_in = erzd_pkg::ST_SWEEP;
         erzd_pkg::ST_SWEEP:
            if (swp_ff == erzd_pkg::SWP_W'(DEPTH + 2)) state_in = erzd_pkg::ST_MUL;
         erzd_pkg::ST_MUL:   state_in = erzd_pkg::ST_PREP;
         erzd_pkg::ST_PREP:
            state_in = (nq_ff > ss_ff && n_ff > erzd_pkg::N_W'(cfg.min_valid))
                       ? erzd_pkg::ST_DIV : erzd_pkg::ST_SCORE;
         erzd_pkg::ST_DIV:
            if (cnt_ff == erzd_pkg::DIVC_W'(X_W - 1)) state_in = erzd_pkg::ST_SQRT;
         erzd_pkg::ST_SQRT:  if (bit_ff == '0) state_in = erzd_pkg::ST_SCORE;
         erzd_pkg::ST_SCORE: state_in = erzd_pkg::ST_OUT;
         erzd_pkg::ST_OUT:   if (rsp_tready) state_in = erzd_pkg::ST_IDLE;
         default:            state_in = erzd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= erzd_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // window store
   always_ff @(posedge clock) begin
      if (state_ff == erzd_pkg::ST_WRITE) mem[ptr_ff] <= tick_ff.rate;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ptr_ff    <= '0;
         rd_ok_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         if (state_ff == erzd_pkg::ST_WRITE) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff <= (ptr_ff == erzd_pkg::PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         end
         rd_ok_ff  <= issue && valid_ff[rd_addr];
         rd_vld_ff <= issue;
         sq_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= (2*CW)'(rd_val) * (2*CW)'(rd_val);
      v2_ff <= rd_val;
      case (state_ff)
         erzd_pkg::ST_IDLE: if (q_valid) tick_ff <= q_data;
         erzd_pkg::ST_WRITE: begin
            swp_ff <= '0;
            n_ff   <= '0;
            s_ff   <= '0;
            qs_ff  <= '0;
         end
         erzd_pkg::ST_SWEEP: begin
            swp_ff <= swp_ff + 1'b1;
            if (sq_vld_ff) begin
               n_ff  <= n_ff + erzd_pkg::N_W'(v2_ff != '0);
               s_ff  <= s_ff + S_W'(v2_ff);
               qs_ff <= qs_ff + erzd_pkg::Q_W'(sq_ff);
            end
         end
         erzd_pkg::ST_MUL: begin
            nq_ff  <= D_W'(n_ff) * D_W'(qs_ff);
            ss_ff  <= D_W'(s_ff) * D_W'(s_ff);
            nr_ff  <= S_W'(n_ff) * S_W'(tick_ff.rate);
            exb_ff <= (tick_ff.execs * cfg.exec_div) > {8'b0, tick_ff.rate};
            spb_ff <= (n_ff != '0) &&
                      ((SPK_W'(tick_ff.rate) * SPK_W'(n_ff)) >
                       (SPK_W'(s_ff) * SPK_W'(cfg.spike_mult)));
         end
         erzd_pkg::ST_PREP: begin
            zen_ff  <= nq_ff > ss_ff && n_ff > erzd_pkg::N_W'(cfg.min_valid);
            d_ff    <= nq_ff - ss_ff;
            neg_ff  <= nr_ff < s_ff;
            quo_ff  <= {D_W'(mag) * D_W'(mag), {(2*erzd_pkg::FRAC_W){1'b0}}};
            rem_ff  <= '0;
            cnt_ff  <= '0;
            root_ff <= '0;
            bit_ff  <= '1;
         end
         erzd_pkg::ST_DIV: begin
            rem_ff <= ge ? D_W'(rem_sh - {1'b0, d_ff}) : D_W'(rem_sh);
            quo_ff <= {quo_ff[X_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         erzd_pkg::ST_SQRT: begin
            if (root_ok) root_ff <= trial;
            bit_ff <= bit_ff - 1'b1;
         end
         erzd_pkg::ST_SCORE: begin
            if (sum > erzd_pkg::SCORE_MAX)      score_ff <= erzd_pkg::SCORE_MAX[15:0];
            else if (sum < erzd_pkg::SCORE_MIN) score_ff <= erzd_pkg::SCORE_MIN[15:0];
            else                                score_ff <= sum[15:0];
         end
         default: ;
      endcase
   end

   `ERZD_ASSERT_ALWAYS(a_ptr_range, ptr_ff < erzd_pkg::PTR_W'(DEPTH), "window pointer out of range")
   `ERZD_ASSERT_ALWAYS(a_n_range, state_ff != erzd_pkg::ST_SWEEP || n_ff <= erzd_pkg::N_W'(DEPTH), "valid count above depth")
   `ERZD_ASSERT_NEXT(a_pop_write, q_pop, state_ff == erzd_pkg::ST_WRITE, "pop not followed by write")

endmodule

`default_nettype wire

// File: sv/event_rate_zscore_detector_core.sv
// ----------------------------------------------------------------------------
// event_rate_zscore_detector_core
// Per-second event rate anomaly detector with rolling z-score.
// ----------------------------------------------------------------------------
// req channel: tuser[0] = 0 for an event beat, 1 for a one-second tick.
// Event beats only bump saturating counters and are taken every cycle.
// A tick closes the second; its counts go into a two-entry queue.
// The back end takes one tick at a time: window write, a sweep of the
// 60-entry window, products, an 80-step serial divide and a 16-step
// serial root, both only when the variance is positive and more than
// min_valid entries are nonzero, then the score. With only ticks coming,
// a full queue takes a new tick only when the back end pops one.
// rsp carries one beat per tick: stamp, rate and signed Q5.10 score.
// If rsp stalls the result is held; ticks then wait in the queue and
// req_tready falls for ticks only, events keep counting.
// Reset (synchronous) clears counters, window and queue, and loads the
// registers with 5, 3 and 10. csr writes take effect at the next edge.
// ----------------------------------------------------------------------------
`default_nettype none

module event_rate_zscore_detector_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // event_kind[1:0], second_stamp[33:2]
   input  wire logic [0:0]  req_tuser,   // req_type[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // second_stamp_out[31:0], event_rate[55:32], score[71:56]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   erzd_pkg::cfg_type  cfg_ff;
   erzd_pkg::tick_type push_data, pop_data;
   logic               q_full, q_push, q_pop, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid  <= erzd_pkg::MIN_VALID_RST;
         cfg_ff.spike_mult <= erzd_pkg::SPIKE_MULT_RST;
         cfg_ff.exec_div   <= erzd_pkg::EXEC_DIV_RST;
      end else if (csr_we) begin
         case (csr_index)
            erzd_pkg::CSR_MIN_VALID:  cfg_ff.min_valid  <= csr_wdata[erzd_pkg::MIN_W-1:0];
            erzd_pkg::CSR_SPIKE_MULT: cfg_ff.spike_mult <= csr_wdata[erzd_pkg::MULT_W-1:0];
            erzd_pkg::CSR_EXEC_DIV:   cfg_ff.exec_div   <= csr_wdata[erzd_pkg::DIV_W-1:0];
            default: ;
         endcase
      end
   end

   erzd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (push_data)
   );

   erzd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_data)
   );

   erzd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_event_rate_zscore_detector_core.sv
// ----------------------------------------------------------------------------
// tb_event_rate_zscore_detector_core
// Self-checking bench: random event/tick streams against a behavioral score.
// ----------------------------------------------------------------------------
// Events and ticks are driven on req; every tick yields one rsp beat whose
// stamp, rate and Q5.10 score are predicted here and compared in order.
// Phases vary the registers and the idle/stall pattern on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_event_rate_zscore_detector_core;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   class zscore_scoreboard;
      int unsigned min_valid, spike_mult, exec_div;
      longint unsigned total_cnt, exec_cnt;
      longint unsigned rates[erzd_pkg::WINDOW_DEPTH];
      int unsigned wr_ptr;
      logic [71:0] pending[$];
      int errors;

      function void clear();
         min_valid = erzd_pkg::MIN_VALID_RST;
         spike_mult = erzd_pkg::SPIKE_MULT_RST;
         exec_div = erzd_pkg::EXEC_DIV_RST;
         total_cnt = 0;
         exec_cnt = 0;
         foreach (rates[i]) rates[i] = 0;
         wr_ptr = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == erzd_pkg::CSR_MIN_VALID) min_valid = val[5:0];
         else if (idx == erzd_pkg::CSR_SPIKE_MULT) spike_mult = val[3:0];
         else if (idx == erzd_pkg::CSR_EXEC_DIV) exec_div = val;
      endfunction

      function void note_input(logic is_tick, logic [1:0] kind, logic [31:0] stamp);
         longint unsigned r, ex, n, s, mag, q, t, cap;
         logic [255:0] sq, dev, num2;
         longint signed score;
         logic neg;
         cap = (64'd1 << erzd_pkg::COUNT_WIDTH) - 1;
         if (!is_tick) begin
            if (total_cnt < cap) total_cnt++;
            if (kind == erzd_pkg::KIND_EXEC && exec_cnt < cap) exec_cnt++;
            return;
         end
         r = total_cnt;
         ex = exec_cnt;
         total_cnt = 0;
         exec_cnt = 0;
         rates[wr_ptr] = r;
         wr_ptr = (wr_ptr + 1) % erzd_pkg::WINDOW_DEPTH;
         n = 0; s = 0; sq = 0; q = 0; neg = 0; score = 0;
         foreach (rates[i]) begin
            if (rates[i] != 0) begin
               n++;
               s += rates[i];
               sq += 256'(rates[i]) * 256'(rates[i]);
            end
         end
         dev = sq * 256'(n);
         num2 = 256'(s) * 256'(s);
         if (dev > num2 && n > min_valid) begin
            dev = dev - num2;
            if (n * r >= s) mag = n * r - s;
            else begin
               mag = s - n * r;
               neg = 1;
            end
            num2 = 256'(mag << 10) * 256'(mag << 10);
            for (int b = 15; b >= 0; b--) begin
               t = q | (64'd1 << b);
               if (dev * 256'(t * t) <= num2) q = t;
            end
            score = neg ? -longint'(q) : longint'(q);
         end
         if (ex * exec_div > r) score += 1024;
         if (n > 0 && r * n > s * spike_mult) score += 1536;
         if (score > 32767) score = 32767;
         if (score < -32768) score = -32768;
         pending.push_back({16'(score), 24'(r > 64'hFFFFFF ? 64'hFFFFFF : r), stamp});
      endfunction

      task check_result(logic [71:0] got);
         logic [71:0] want;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected result %h", got));
            return;
         end
         want = pending.pop_front();
         if (got[31:0] != want[31:0])
            report_error($sformatf("stamp %h want %h", got[31:0], want[31:0]));
         if (got[55:32] != want[55:32])
            report_error($sformatf("rate %0d want %0d", got[55:32], want[55:32]));
         if (got[71:56] != want[71:56])
            report_error($sformatf("score %0d want %0d stamp %h",
               $signed(got[71:56]), $signed(want[71:56]), want[31:0]));
      endtask

      task report_error(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   zscore_scoreboard sb;
   int send_idle_pct;
   int stall_pct;
   int hold_off;
   longint cycle_count;

   event_rate_zscore_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side: random stall, plus long hold-off when requested
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 0;
            hold_off--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task automatic send_beat(logic is_tick, logic [1:0] kind, logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_tick;
      req_tdata <= {6'd0, stamp, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(is_tick, kind, stamp);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   // one second of traffic: a burst of events then a tick
   task automatic send_second(int n_events, int exec_pct, logic [31:0] stamp);
      for (int i = 0; i < n_events; i++)
         send_beat(0, ($urandom_range(99) < exec_pct) ? erzd_pkg::KIND_EXEC
                      : 2'($urandom_range(3, 1)), $urandom);
      send_beat(1, 2'($urandom), stamp);
   endtask

   task automatic random_phase(int n_ticks, int base);
      for (int i = 0; i < n_ticks; i++) begin
         if ($urandom_range(9) == 0)
            send_second($urandom_range(0, 3 * base), $urandom_range(100), $urandom);
         else
            send_second($urandom_range(base / 2, base + base / 2), $urandom_range(30),
                        $urandom);
      end
   endtask

   initial begin
      logic [31:0] stamp;
      sb = new();
      sb.clear();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty window, every kind, extreme stamps, unknown index
      send_beat(1, 2'd3, 32'hFFFFFFFF);
      send_beat(0, 2'd0, 32'hFFFFFFFF);
      send_beat(0, 2'd1, 32'h0);
      send_beat(0, 2'd2, 32'h0);
      send_beat(0, 2'd3, 32'hA5A5A5A5);
      send_beat(1, 2'd0, 32'h0);
      for (int i = 0; i < 8; i++) send_second(i % 4 + 1, 50, 32'h100 + i);
      send_second(40, 0, 32'h5555AAAA);
      quiesce();
      write_reg(CSR_UNUSED, 8'hFF);
      write_reg(erzd_pkg::CSR_MIN_VALID, 8'd0);
      write_reg(erzd_pkg::CSR_SPIKE_MULT, 8'd0);
      write_reg(erzd_pkg::CSR_EXEC_DIV, 8'd0);
      send_second(3, 100, 32'h1);
      send_second(1, 0, 32'h2);
      quiesce();

      // full window with wide spread, extreme registers
      write_reg(erzd_pkg::CSR_MIN_VALID, 8'd60);
      write_reg(erzd_pkg::CSR_SPIKE_MULT, 8'd15);
      write_reg(erzd_pkg::CSR_EXEC_DIV, 8'd255);
      random_phase(62, 2);
      quiesce();

      // idle/stall phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 55 : 34) : 0;
         stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 55 : 34) : 0;
         write_reg(erzd_pkg::CSR_MIN_VALID, 8'($urandom_range(0, 8)));
         write_reg(erzd_pkg::CSR_SPIKE_MULT, 8'($urandom_range(1, 5)));
         write_reg(erzd_pkg::CSR_EXEC_DIV, 8'($urandom_range(1, 20)));
         random_phase(12, 2);
         quiesce();
      end

      // receiver hold-off: ticks pile up and req stalls
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(erzd_pkg::CSR_MIN_VALID, erzd_pkg::MIN_VALID_RST);
      write_reg(erzd_pkg::CSR_SPIKE_MULT, erzd_pkg::SPIKE_MULT_RST);
      write_reg(erzd_pkg::CSR_EXEC_DIV, erzd_pkg::EXEC_DIV_RST);
      hold_off = 3000;
      for (int i = 0; i < 12; i++) begin
         stamp = $urandom;
         send_beat(1, 2'd2, stamp);
         send_beat(0, erzd_pkg::KIND_EXEC, stamp);
      end
      quiesce();

      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/erzd_pkg.sv
sv/erzd_front.sv
sv/erzd_queue.sv
sv/erzd_back.sv
sv/event_rate_zscore_detector_core.sv
tb/sv/tb_event_rate_zscore_detector_core.sv
